/* rtl/core/ede_pkg.sv */
// Shared types and constants of the edit distance engine.
package ede_pkg;

   localparam int SYM_W  = 8;
   localparam int MODE_W = 2;
   localparam int DIST_W = 9;

   localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

   localparam logic [MODE_W-1:0] MODE_SECOND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

   typedef struct packed {
      logic sym_wr;
      logic sweep_go;
      logic tail_rd;
   } row_cmd_type;

endpackage

/* rtl/core/ede_if.sv */
// Valid/ready channel interfaces for request and response transactions.
interface ede_req_if;
   logic                            valid;
   logic                            ready;
   logic [ede_pkg::MODE_W-1:0]      mode;
   logic [ede_pkg::SYM_W-1:0]       symbol;

   modport source (output valid, output mode, output symbol, input ready);
   modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface ede_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ede_pkg::DIST_W-1:0]      distance;
   logic                            overflow;

   modport source (output valid, output distance, output overflow, input ready);
   modport sink   (input valid, input distance, input overflow, output ready);
endinterface

/* rtl/core/ede_row_unit.sv */
// String store, DP row memory and the per-symbol row sweep.
module ede_row_unit #(
   parameter int MAX_LEN = 256,
   parameter int LEN_W   = 9,
   parameter int ADDR_W  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ede_pkg::row_cmd_type       cmd,
   input  logic [ede_pkg::SYM_W-1:0]  sym,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [LEN_W-1:0]           len,
   input  logic [LEN_W-1:0]           first_len,
   output logic                       busy,
   output logic [LEN_W-1:0]           tail_data
);

   logic [ede_pkg::SYM_W-1:0] str_mem [MAX_LEN];
   logic [LEN_W-1:0]          dp_mem  [MAX_LEN];

   logic                      issuing_ff;
   logic [ADDR_W-1:0]         issue_idx_ff;
   logic [ADDR_W-1:0]         last_idx_ff;
   logic                      stage_vld_ff;
   logic [ADDR_W-1:0]         stage_idx_ff;
   logic [ede_pkg::SYM_W-1:0] sym_ff;
   logic                      first_row_ff;
   logic [LEN_W-1:0]          diag_ff;
   logic [LEN_W-1:0]          left_ff;
   logic [ede_pkg::SYM_W-1:0] str_q_ff;
   logic [LEN_W-1:0]          dp_q_ff;

   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [LEN_W-1:0]          up;
   logic [LEN_W:0]            cand_diag;
   logic [LEN_W:0]            cand_up;
   logic [LEN_W:0]            cand_left;
   logic [LEN_W:0]            cand_min;
   logic [LEN_W-1:0]          cell_in;

   always_comb begin
      rd_en     = issuing_ff | cmd.tail_rd;
      rd_addr   = issuing_ff ? issue_idx_ff : addr;
      up        = first_row_ff ? (LEN_W'(stage_idx_ff) + LEN_W'(1)) : dp_q_ff;
      cand_diag = {1'b0, diag_ff} + (LEN_W+1)'(str_q_ff != sym_ff);
      cand_up   = {1'b0, up} + (LEN_W+1)'(1);
      cand_left = {1'b0, left_ff} + (LEN_W+1)'(1);
      cand_min  = (cand_diag < cand_up) ? cand_diag : cand_up;
      if (cand_left < cand_min) begin
         cand_min = cand_left;
      end
      cell_in   = cand_min[LEN_W-1:0];
   end

   assign busy      = issuing_ff | stage_vld_ff;
   assign tail_data = dp_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff   <= 1'b0;
         stage_vld_ff <= 1'b0;
      end else begin
         if (cmd.sweep_go) begin
            issuing_ff   <= 1'b1;
            issue_idx_ff <= '0;
            last_idx_ff  <= ADDR_W'(len - LEN_W'(1));
            sym_ff       <= sym;
            first_row_ff <= (first_len == '0);
            diag_ff      <= first_len;
            left_ff      <= first_len + LEN_W'(1);
         end else if (issuing_ff) begin
            if (issue_idx_ff == last_idx_ff) begin
               issuing_ff <= 1'b0;
            end
            issue_idx_ff <= issue_idx_ff + ADDR_W'(1);
         end
         stage_vld_ff <= issuing_ff;
         stage_idx_ff <= issue_idx_ff;
         if (stage_vld_ff) begin
            diag_ff <= up;
            left_ff <= cell_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         str_q_ff <= str_mem[rd_addr];
         dp_q_ff  <= dp_mem[rd_addr];
      end
      if (cmd.sym_wr) begin
         str_mem[addr] <= sym;
      end
      if (stage_vld_ff) begin
         dp_mem[stage_idx_ff] <= cell_in;
      end
   end

endmodule

/* rtl/core/edit_distance_engine_core.sv */
// Levenshtein edit distance engine: sequencing, lengths and response register.
// Second-string symbol: accepted without leaving S_IDLE, so ready stays high.
// First-string symbol: one DP cell per cycle from the row memory port,
//   for each of the n cells, with n the second-string length (n <= MAX_LEN).
// End transaction: state moves to S_END, then the response register loads once it is free.
// Synchronous reset clears lengths, flags and control; memories are not cleared.
module edit_distance_engine_core #(
   parameter int MAX_LEN = 256
) (
   input  logic            clock,
   input  logic            reset,
   ede_req_if.sink         req_chan,
   ede_rsp_if.source       rsp_chan
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int EXT_W  = (LEN_W > ede_pkg::DIST_W) ? LEN_W : ede_pkg::DIST_W;

   typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_END} state_type;

   state_type                   state_ff;
   logic [LEN_W-1:0]            first_len_ff;
   logic [LEN_W-1:0]            second_len_ff;
   logic                        ovf_ff;
   logic                        rsp_valid_ff;
   logic [ede_pkg::DIST_W-1:0]  rsp_dist_ff;
   logic                        rsp_ovf_ff;

   ede_pkg::row_cmd_type        cmd;
   logic                        accept;
   logic                        busy;
   logic [LEN_W-1:0]            tail_data;
   logic [ADDR_W-1:0]           addr;
   logic [LEN_W-1:0]            dist_raw;
   logic [EXT_W-1:0]            dist_ext;
   logic [ede_pkg::DIST_W-1:0]  dist_in;
   logic                        first_full;
   logic                        second_full;
   logic                        rsp_load;

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

   always_comb begin
      accept      = req_chan.valid & req_chan.ready;
      first_full  = (first_len_ff >= LEN_W'(MAX_LEN));
      second_full = (second_len_ff >= LEN_W'(MAX_LEN));
      cmd.sym_wr   = accept && (req_chan.mode == ede_pkg::MODE_SECOND) &&
                     (first_len_ff == '0) && !second_full;
      cmd.sweep_go = accept && (req_chan.mode == ede_pkg::MODE_FIRST) &&
                     !first_full && (second_len_ff != '0);
      cmd.tail_rd  = accept && (req_chan.mode == ede_pkg::MODE_END) &&
                     (first_len_ff != '0) && (second_len_ff != '0);
      addr = (req_chan.mode == ede_pkg::MODE_END) ?
             ADDR_W'(second_len_ff - LEN_W'(1)) : ADDR_W'(second_len_ff);
      if (first_len_ff == '0) begin
         dist_raw = second_len_ff;
      end else if (second_len_ff == '0) begin
         dist_raw = first_len_ff;
      end else begin
         dist_raw = tail_data;
      end
      dist_ext = EXT_W'(dist_raw);
      dist_in  = (dist_ext > EXT_W'(ede_pkg::DIST_MAX)) ?
                 ede_pkg::DIST_MAX : dist_ext[ede_pkg::DIST_W-1:0];
      rsp_load = (state_ff == S_END) && (!rsp_valid_ff || rsp_chan.ready);
   end

   ede_row_unit #(
      .MAX_LEN (MAX_LEN),
      .LEN_W   (LEN_W),
      .ADDR_W  (ADDR_W)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sym       (req_chan.symbol),
      .addr      (addr),
      .len       (second_len_ff),
      .first_len (first_len_ff),
      .busy      (busy),
      .tail_data (tail_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_dist_ff  <= dist_in;
            rsp_ovf_ff   <= ovf_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_chan.mode)
                     ede_pkg::MODE_SECOND: begin
                        if (first_len_ff == '0) begin
                           if (second_full) begin
                              ovf_ff <= 1'b1;
                           end else begin
                              second_len_ff <= second_len_ff + LEN_W'(1);
                           end
                        end
                     end
                     ede_pkg::MODE_FIRST: begin
                        if (first_full) begin
                           ovf_ff <= 1'b1;
                        end else begin
                           first_len_ff <= first_len_ff + LEN_W'(1);
                           if (second_len_ff != '0) begin
                              state_ff <= S_SWEEP;
                           end
                        end
                     end
                     ede_pkg::MODE_END: begin
                        state_ff <= S_END;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SWEEP: begin
               if (!busy) begin
                  state_ff <= S_IDLE;
               end
            end
            S_END: begin
               if (rsp_load) begin
                  first_len_ff  <= '0;
                  second_len_ff <= '0;
                  ovf_ff        <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/core/ede_checker.sv */
// Port-level checks of the edit distance engine, bound to the top level.
module ede_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [ede_pkg::MODE_W-1:0]  req_mode,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ede_pkg::DIST_W-1:0]  rsp_distance,
   input logic                        rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance) &&
                                  $stable(rsp_overflow))
      else $error("response dropped or changed while stalled");

   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == ede_pkg::MODE_END) |=> !req_ready)
      else $error("request taken while end transaction in flight");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a pending end transaction");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind edit_distance_engine_core ede_checker u_ede_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_mode     (req_chan.mode),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_distance (rsp_chan.distance),
   .rsp_overflow (rsp_chan.overflow)
);

/* dv/ede_distance_checker.sv */
// Edit distance checker: watches request and response channels, predicts and compares.
`timescale 1ns / 1ps

module ede_distance_checker
   import ede_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  logic clock,
   input  logic reset,
   ede_req_if   req_mon,
   ede_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } distance_result_t;

   distance_result_t  expected_distances [$];
   distance_result_t  oldest;

   logic [SYM_W-1:0]  second_syms [MAX_LEN];
   logic [DIST_W-1:0] dist_row    [MAX_LEN];
   int unsigned       second_len;
   int unsigned       first_len;
   logic              trunc_seen;
   int                mismatches;

   task automatic update_distance_model(input logic [MODE_W-1:0] mode,
                                        input logic [SYM_W-1:0] sym);
      int unsigned      k;
      int unsigned      up;
      int unsigned      diag;
      int unsigned      left;
      int unsigned      entry;
      int unsigned      d;
      distance_result_t res;
      case (mode)
         MODE_SECOND: begin
            if (first_len == 0) begin
               if (second_len >= MAX_LEN) begin
                  trunc_seen = 1'b1;
               end else begin
                  second_syms[second_len] = sym;
                  second_len++;
               end
            end
         end
         MODE_FIRST: begin
            if (first_len >= MAX_LEN) begin
               trunc_seen = 1'b1;
            end else begin
               diag = first_len;
               left = first_len + 1;
               for (k = 1; k <= second_len; k++) begin
                  up    = (first_len == 0) ? k : dist_row[k-1];
                  entry = diag + ((second_syms[k-1] == sym) ? 0 : 1);
                  if (up + 1 < entry) entry = up + 1;
                  if (left + 1 < entry) entry = left + 1;
                  dist_row[k-1] = entry[DIST_W-1:0];
                  diag = up;
                  left = entry;
               end
               first_len++;
            end
         end
         MODE_END: begin
            if (first_len == 0)
               d = second_len;
            else if (second_len == 0)
               d = first_len;
            else
               d = dist_row[second_len-1];
            if (d > DIST_MAX) d = DIST_MAX;
            res.distance = d[DIST_W-1:0];
            res.overflow = trunc_seen;
            expected_distances.push_back(res);
            first_len  = 0;
            second_len = 0;
            trunc_seen = 1'b0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_distances.delete();
         second_len = 0;
         first_len  = 0;
         trunc_seen = 1'b0;
         mismatches = 0;
      end else begin
         // response first: a result never belongs to an end taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected result: distance %0d overflow %0b",
                        $time, rsp_mon.distance, rsp_mon.overflow);
               mismatches++;
            end else begin
               oldest = expected_distances.pop_front();
               if (rsp_mon.distance !== oldest.distance) begin
                  $display("%0t: distance mismatch: expected %0d, actual %0d",
                           $time, oldest.distance, rsp_mon.distance);
                  mismatches++;
               end
               if (rsp_mon.overflow !== oldest.overflow) begin
                  $display("%0t: overflow mismatch: expected %0b, actual %0b",
                           $time, oldest.overflow, rsp_mon.overflow);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            update_distance_model(req_mon.mode, req_mon.symbol);
      end
      fail_count <= mismatches;
      pending    <= expected_distances.size();
   end

endmodule

/* dv/tb_edit_distance_engine_core.sv */
// Testbench top for the edit distance engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_edit_distance_engine_core;
   import ede_pkg::*;

   localparam int                MAX_LEN     = 256;
   localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd3;
   localparam int                ITEM_TARGET = 1450;
   localparam int                CYCLE_LIMIT = 2_000_000;
   localparam int                LONG_STALL  = 400;
   localparam int                STALL_AT    = 40;
   localparam int                DRAIN_PAIR  = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   item_count;
   int   results_taken;
   int   cycle_count;
   bit   tx_calm;
   bit   rx_calm;
   bit   stalled_once;

   ede_req_if req_bus ();
   ede_rsp_if rsp_bus ();

   edit_distance_engine_core #(.MAX_LEN(MAX_LEN)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   ede_distance_checker #(.MAX_LEN(MAX_LEN)) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= mode;
      req_bus.symbol <= sym;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (mode != MODE_IDLE) item_count++;
   endtask

   // narrow: symbols from a three-letter alphabet so matches are common
   task automatic send_pair(input int n_second, input int n_first,
                            input bit narrow, input bit noisy);
      logic [2:0][SYM_W-1:0] letters;
      int                    i;
      for (i = 0; i < 3; i++) letters[i] = SYM_W'($urandom_range(0, 255));
      tx_calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < n_second; i++) begin
         if (noisy && $urandom_range(0, 5) == 0)
            send_item(MODE_IDLE, SYM_W'($urandom_range(0, 255)));
         send_item(MODE_SECOND,
                   narrow ? letters[$urandom_range(0, 2)] : SYM_W'($urandom_range(0, 255)));
      end
      for (i = 0; i < n_first; i++) begin
         if (noisy && $urandom_range(0, 5) == 0)
            send_item($urandom_range(0, 1) ? MODE_IDLE : MODE_SECOND,
                      SYM_W'($urandom_range(0, 255)));
         send_item(MODE_FIRST,
                   narrow ? letters[$urandom_range(0, 2)] : SYM_W'($urandom_range(0, 255)));
      end
      send_item(MODE_END, SYM_W'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // response side: random hold-off per transaction, one long stall
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results_taken % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         gap = rx_calm ? 0 : $urandom_range(0, 7);
         if (!stalled_once && results_taken == STALL_AT) begin
            gap          = LONG_STALL;
            stalled_once = 1'b1;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         results_taken++;
      end
   end

   initial begin
      int pair_idx;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.mode   = MODE_SECOND;
      req_bus.symbol = '0;
      cycle_count    = 0;
      item_count     = 0;
      results_taken  = 0;
      tx_calm        = 1'b0;
      rx_calm        = 1'b0;
      stalled_once   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: both empty
      send_item(MODE_END, 8'h00);
      // only second string, extreme symbols
      send_item(MODE_SECOND, 8'h00);
      send_item(MODE_SECOND, 8'hFF);
      send_item(MODE_END, 8'hFF);
      // only first string
      send_item(MODE_FIRST, 8'hFF);
      send_item(MODE_FIRST, 8'h00);
      send_item(MODE_FIRST, 8'h5A);
      send_item(MODE_END, 8'h00);
      // identical strings
      send_item(MODE_SECOND, 8'h41);
      send_item(MODE_SECOND, 8'h42);
      send_item(MODE_SECOND, 8'h43);
      send_item(MODE_FIRST, 8'h41);
      send_item(MODE_FIRST, 8'h42);
      send_item(MODE_FIRST, 8'h43);
      send_item(MODE_END, 8'h00);
      // swapped pair, mode three, late second-string symbol
      send_item(MODE_SECOND, 8'h10);
      send_item(MODE_SECOND, 8'h20);
      send_item(MODE_FIRST, 8'h20);
      send_item(MODE_IDLE, 8'hAA);
      send_item(MODE_FIRST, 8'h10);
      send_item(MODE_SECOND, 8'h30);
      send_item(MODE_END, 8'h55);

      pair_idx = 0;
      while (item_count < ITEM_TARGET) begin
         case (pair_idx)
            3:       send_pair(MAX_LEN + $urandom_range(1, 2), $urandom_range(1, 3), 1'b1, 1'b0);
            9:       send_pair($urandom_range(0, 2), MAX_LEN + $urandom_range(1, 2), 1'b1, 1'b0);
            15:      send_pair(MAX_LEN, 0, 1'b0, 1'b0);
            default: send_pair($urandom_range(0, 10), $urandom_range(0, 10),
                               $urandom_range(0, 9) < 7, $urandom_range(0, 3) == 0);
         endcase
         if (pair_idx == DRAIN_PAIR) wait_drained();
         pair_idx++;
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
